// ----- hdl/vknd_pkg.sv -----
// Shared types and constants of the keyframe NAL detector.
package vknd_pkg;

  localparam int ByteW = 8;
  localparam int LenW  = 21;
  localparam int ModeW = 3;

  localparam logic [ModeW-1:0] CODEC_H264  = 3'd0;
  localparam logic [ModeW-1:0] CODEC_H265  = 3'd1;
  localparam logic [ModeW-1:0] CODEC_VP8   = 3'd2;
  localparam logic [ModeW-1:0] CODEC_OTHER = 3'd3;
  localparam logic [ModeW-1:0] CODEC_AUDIO = 3'd4;

  localparam logic [4:0] H264_IDR_TYPE     = 5'd5;
  localparam logic [5:0] H265_IRAP_FIRST   = 6'd16;
  localparam logic [5:0] H265_IRAP_LAST    = 6'd21;
  localparam logic [LenW-1:0] POS_MAX      = {LenW{1'b1}};

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0]  buffer_length;
    logic             delta_flag;
    logic             last_byte;
  } item_t;

endpackage

// ----- hdl/vknd_if.sv -----
// Handshake channels of the keyframe NAL detector: byte input and verdict output.
interface vknd_in_if;
  logic                          valid;
  logic                          ready;
  logic [vknd_pkg::ByteW-1:0]    data_byte;
  logic [vknd_pkg::LenW-1:0]     buffer_length;
  logic                          delta_flag;
  logic                          last_byte;

  modport source(output valid, data_byte, buffer_length, delta_flag, last_byte,
                 input ready);
  modport sink(input valid, data_byte, buffer_length, delta_flag, last_byte,
               output ready);
endinterface

interface vknd_out_if;
  logic valid;
  logic ready;
  logic key_frame;

  modport source(output valid, key_frame, input ready);
  modport sink(input valid, key_frame, output ready);
endinterface

// ----- hdl/vknd_in_reg.sv -----
// Input register of the keyframe NAL detector.
module vknd_in_reg (
  input  logic            clk,
  input  logic            rst,
  vknd_in_if.sink         src,
  input  logic            advance,
  output logic            item_valid,
  output vknd_pkg::item_t item
);

  logic valid_q;

  assign src.ready  = !valid_q || advance;
  assign item_valid = valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (src.ready) begin
      valid_q <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      item.data_byte     <= src.data_byte;
      item.buffer_length <= src.buffer_length;
      item.delta_flag    <= src.delta_flag;
      item.last_byte     <= src.last_byte;
    end
  end

endmodule

// ----- hdl/vknd_scan.sv -----
// Per-buffer scan state: start-code search, length-prefix walk and keyframe verdict.
module vknd_scan #(
  parameter int MAX_BUFFER_BYTES = 1048576
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  vknd_pkg::item_t            item,
  input  logic [vknd_pkg::ModeW-1:0] codec_mode,
  output logic                       key
);

  localparam int LW = vknd_pkg::LenW;
  localparam logic [24:0] MaxBytes = 25'(MAX_BUFFER_BYTES);

  logic [LW-1:0] byte_position, byte_position_next;
  logic [31:0]   recent_bytes, recent_bytes_next;
  logic [LW-1:0] next_prefix_position, next_prefix_position_next;
  logic          header_pending, header_pending_next;
  logic          prefix_scan_stopped, prefix_scan_stopped_next;
  logic          key_found, key_found_next;

  logic [24:0]   size_wide;
  logic [LW-1:0] size;
  logic          nal_codec;
  logic          in_window;
  logic          start3;
  logic          start4;
  logic          header;
  logic          random_access;
  logic [5:0]    h265_type;
  logic          prefix_end;
  logic [31:0]   nal_len;
  logic          prefix_fits;
  logic          nal_fits;

  always_comb begin
    size_wide = ({4'b0, item.buffer_length} > MaxBytes) ? MaxBytes
                                                        : {4'b0, item.buffer_length};
    size      = size_wide[LW-1:0];
    nal_codec = (codec_mode == vknd_pkg::CODEC_H264) || (codec_mode == vknd_pkg::CODEC_H265);
    in_window = byte_position < size;

    start3 = (byte_position >= LW'(3)) && (recent_bytes[23:0] == 24'h000001) &&
             (({1'b0, byte_position} + (LW+1)'(1)) < {1'b0, size});
    start4 = (byte_position >= LW'(4)) && (recent_bytes == 32'h00000001);
    header = start3 || start4 || header_pending;

    h265_type = item.data_byte[6:1];
    case (codec_mode)
      vknd_pkg::CODEC_H264: random_access = item.data_byte[4:0] == vknd_pkg::H264_IDR_TYPE;
      vknd_pkg::CODEC_H265: random_access = (h265_type >= vknd_pkg::H265_IRAP_FIRST) &&
                                            (h265_type <= vknd_pkg::H265_IRAP_LAST);
      default:              random_access = 1'b0;
    endcase

    // The prefix ends on its fourth byte; its value is the three older bytes plus this one.
    prefix_end  = !prefix_scan_stopped &&
                  ({1'b0, byte_position} == ({1'b0, next_prefix_position} + (LW+1)'(3)));
    nal_len     = {recent_bytes[23:0], item.data_byte};
    prefix_fits = ({1'b0, next_prefix_position} + (LW+1)'(5)) <= {1'b0, size};
    nal_fits    = (nal_len != 32'd0) &&
                  (({12'b0, next_prefix_position} + 33'd4 + {1'b0, nal_len}) <=
                   {12'b0, size});

    byte_position_next        = byte_position;
    recent_bytes_next         = {recent_bytes[23:0], item.data_byte};
    next_prefix_position_next = next_prefix_position;
    header_pending_next       = header_pending;
    prefix_scan_stopped_next  = prefix_scan_stopped;
    key_found_next            = key_found;

    if (byte_position != vknd_pkg::POS_MAX) begin
      byte_position_next = byte_position + LW'(1);
    end

    if (nal_codec && in_window) begin
      if (header && random_access) begin
        key_found_next = 1'b1;
      end
      if (header_pending) begin
        header_pending_next = 1'b0;
      end
      if (prefix_end) begin
        if (!prefix_fits || !nal_fits) begin
          prefix_scan_stopped_next = 1'b1;
        end else begin
          // The byte straight after the prefix is the NAL header.
          header_pending_next       = 1'b1;
          next_prefix_position_next = byte_position + LW'(1) + nal_len[LW-1:0];
        end
      end
    end

    if ((byte_position == '0) && (codec_mode == vknd_pkg::CODEC_VP8)) begin
      key_found_next = !item.data_byte[0];
    end

    case (codec_mode)
      vknd_pkg::CODEC_H264,
      vknd_pkg::CODEC_H265,
      vknd_pkg::CODEC_VP8:   key = key_found_next;
      vknd_pkg::CODEC_AUDIO: key = 1'b1;
      default:               key = !item.delta_flag;
    endcase

    if (item.last_byte) begin
      byte_position_next        = '0;
      recent_bytes_next         = '0;
      next_prefix_position_next = '0;
      header_pending_next       = 1'b0;
      prefix_scan_stopped_next  = 1'b0;
      key_found_next            = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      recent_bytes         <= '0;
      next_prefix_position <= '0;
      header_pending       <= 1'b0;
      prefix_scan_stopped  <= 1'b0;
      key_found            <= 1'b0;
    end else if (advance) begin
      byte_position        <= byte_position_next;
      recent_bytes         <= recent_bytes_next;
      next_prefix_position <= next_prefix_position_next;
      header_pending       <= header_pending_next;
      prefix_scan_stopped  <= prefix_scan_stopped_next;
      key_found            <= key_found_next;
    end
  end

endmodule

// ----- hdl/video_keyframe_nal_detector.sv -----
// Top level of the keyframe NAL detector: input register, scan logic and verdict register.
//
// The bytes channel carries one byte of a compressed buffer per transfer, together
// with the buffer's length, its delta flag and a mark on its final byte. The verdict
// channel carries one key_frame bit per buffer, produced by the final byte.
// codec_mode is written through cfg_write/cfg_data; the user must do so only while no
// buffer is in flight, as the block itself does not enforce this. Each transferred
// byte is evaluated by the scan logic from the input register; the verdict of a buffer
// is registered when its final byte is evaluated. One byte per cycle is taken in steady
// state unless a final byte waits for a pending verdict; the scan state updates per byte.
// While a verdict waits for the receiver, ordinary bytes keep flowing; only the next
// buffer's final byte is held in the input register until the verdict is taken.
// Reset clears the channel state, the scan state and sets codec_mode to H.264.
module video_keyframe_nal_detector #(
  parameter int MAX_BUFFER_BYTES = 1048576
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [vknd_pkg::ModeW-1:0] cfg_data,
  vknd_in_if.sink                    bytes,
  vknd_out_if.source                 verdict
);

  logic                       item_valid;
  vknd_pkg::item_t            item;
  logic                       advance;
  logic                       key;
  logic [vknd_pkg::ModeW-1:0] codec_mode;
  logic                       out_valid;
  logic                       out_key;

  assign advance = item_valid && (!item.last_byte || !out_valid || verdict.ready);

  vknd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .src        (bytes),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  vknd_scan #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (item),
    .codec_mode (codec_mode),
    .key        (key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode <= vknd_pkg::CODEC_H264;
    end else if (cfg_write) begin
      codec_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && item.last_byte) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last_byte) begin
      out_key <= key;
    end
  end

  assign verdict.valid     = out_valid;
  assign verdict.key_frame = out_key;

`ifndef SYNTH
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    advance && item.last_byte |=> out_valid)
    else $error("final byte evaluated without a verdict");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !verdict.ready |-> !(advance && item.last_byte))
    else $error("pending verdict overwritten");

  a_audio_key: assert property (@(posedge clk) disable iff (rst)
    advance && item.last_byte && (codec_mode == vknd_pkg::CODEC_AUDIO) |=> out_key)
    else $error("audio buffer not marked as keyframe");
`endif

endmodule

// ----- test/tb.sv -----
// Testbench of the keyframe NAL detector: directed and random buffers checked against a model.
module tb;

  localparam int MaxBytes = 1048576;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [vknd_pkg::ModeW-1:0] cfg_data;

  vknd_in_if  in_ch ();
  vknd_out_if out_ch ();

  video_keyframe_nal_detector #(
    .MAX_BUFFER_BYTES(MaxBytes)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .bytes    (in_ch),
    .verdict  (out_ch)
  );

  always #6 clk = ~clk;

  // Model of the scan state, kept in step with the transfers on the byte channel.
  logic [vknd_pkg::ModeW-1:0] codec_now;
  logic [vknd_pkg::LenW-1:0]  scan_pos;
  logic [31:0]                last_four;
  logic [vknd_pkg::LenW-1:0]  prefix_at;
  logic [31:0]                nal_len_pending;
  bit                         walk_stopped;
  bit                         key_seen;

  logic                       expected_verdicts[$];
  logic [vknd_pkg::ByteW-1:0] frame[$];
  logic                       wanted_key;

  int errors;
  int bytes_sent;
  int buffers_sent;
  int verdicts_checked;
  int stall_left;
  bit rush;

  function automatic void clear_scan();
    scan_pos        = '0;
    last_four       = '0;
    prefix_at       = '0;
    nal_len_pending = '0;
    walk_stopped    = 1'b0;
    key_seen        = 1'b0;
  endfunction

  function automatic bit random_access_nal(logic [vknd_pkg::ByteW-1:0] hdr);
    if (codec_now == vknd_pkg::CODEC_H264) begin
      return hdr[4:0] == vknd_pkg::H264_IDR_TYPE;
    end
    if (codec_now == vknd_pkg::CODEC_H265) begin
      return hdr[6:1] >= vknd_pkg::H265_IRAP_FIRST && hdr[6:1] <= vknd_pkg::H265_IRAP_LAST;
    end
    return 1'b0;
  endfunction

  function automatic void scan_byte(input vknd_pkg::item_t it, output bit due,
                                    output logic key);
    longint unsigned limit;
    longint unsigned p;
    longint unsigned q;
    logic [31:0]     word;
    bit              header;
    bit              nal_codec;
    limit = it.buffer_length;
    if (limit > MaxBytes) begin
      limit = MaxBytes;
    end
    p = scan_pos;
    nal_codec = codec_now == vknd_pkg::CODEC_H264 || codec_now == vknd_pkg::CODEC_H265;
    if (nal_codec && p < limit) begin
      header = 1'b0;
      // A short start code only counts when the header byte is not the buffer's final one.
      if (p >= 3 && last_four[23:0] == 24'h000001 && p + 1 < limit) begin
        header = 1'b1;
      end
      if (p >= 4 && last_four == 32'h00000001) begin
        header = 1'b1;
      end
      if (nal_len_pending != 0 && p + nal_len_pending == prefix_at) begin
        header = 1'b1;
        nal_len_pending = '0;
      end
      if (header && random_access_nal(it.data_byte)) begin
        key_seen = 1'b1;
      end
      if (!walk_stopped && p == prefix_at + 3) begin
        q = prefix_at;
        if (q + 5 > limit) begin
          walk_stopped = 1'b1;
        end else begin
          word = {last_four[23:0], it.data_byte};
          if (word == 0 || q + 4 + word > limit) begin
            walk_stopped = 1'b1;
          end else begin
            nal_len_pending = word;
            prefix_at = vknd_pkg::LenW'(p + 1 + word);
          end
        end
      end
    end
    if (p == 0 && codec_now == vknd_pkg::CODEC_VP8) begin
      key_seen = it.data_byte[0] == 1'b0;
    end
    last_four = {last_four[23:0], it.data_byte};
    if (scan_pos != vknd_pkg::POS_MAX) begin
      scan_pos = scan_pos + 1'b1;
    end
    due = it.last_byte;
    key = 1'b0;
    if (due) begin
      if (nal_codec || codec_now == vknd_pkg::CODEC_VP8) begin
        key = key_seen;
      end else if (codec_now == vknd_pkg::CODEC_AUDIO) begin
        key = 1'b1;
      end else begin
        key = !it.delta_flag;
      end
      clear_scan();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // The receiver holds off now and then, except during stretches at full rate.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!rush && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: verdict transfer with none expected, actual key_frame=%0b",
                 $time, out_ch.key_frame);
        errors++;
      end else begin
        wanted_key = expected_verdicts.pop_front();
        verdicts_checked++;
        if (out_ch.key_frame !== wanted_key) begin
          $display("%0t: key_frame mismatch, expected %0b, actual %0b",
                   $time, wanted_key, out_ch.key_frame);
          errors++;
        end
      end
    end
  end

  task automatic send_byte(input logic [vknd_pkg::ByteW-1:0] d,
                           input logic [vknd_pkg::LenW-1:0] len,
                           input logic delta, input logic last);
    vknd_pkg::item_t it;
    bit              due;
    logic            key;
    int              gap;
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= d;
    in_ch.buffer_length <= len;
    in_ch.delta_flag    <= delta;
    in_ch.last_byte     <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    it = '{data_byte: d, buffer_length: len, delta_flag: delta, last_byte: last};
    scan_byte(it, due, key);
    if (due) begin
      expected_verdicts = {expected_verdicts, key};
    end
    bytes_sent++;
    gap = rush ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input int len, input logic delta);
    foreach (frame[i]) begin
      send_byte(frame[i], vknd_pkg::LenW'(len), delta, i == frame.size() - 1);
    end
    frame.delete();
    buffers_sent++;
  endtask

  // Waits until every verdict has come back, then lets the pipeline drain.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_codec(input logic [vknd_pkg::ModeW-1:0] mode);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    cfg_write <= 1'b0;
    codec_now = mode;
  endtask

  function automatic void add_prefix(input int unsigned n);
    frame = {frame, n[31:24], n[23:16], n[15:8], n[7:0]};
  endfunction

  function automatic void add_body(input int n);
    repeat (n) frame = {frame, vknd_pkg::ByteW'($urandom)};
  endfunction

  // About half the headers are random access types; for H.265 the neighbours of the range too.
  function automatic logic [vknd_pkg::ByteW-1:0] pick_header();
    logic [vknd_pkg::ByteW-1:0] hdr;
    hdr = vknd_pkg::ByteW'($urandom);
    if ($urandom_range(0, 1) == 1) begin
      if (codec_now == vknd_pkg::CODEC_H265) begin
        hdr[6:1] = 6'($urandom_range(15, 22));
      end else begin
        hdr[4:0] = vknd_pkg::H264_IDR_TYPE;
      end
    end
    return hdr;
  endfunction

  task automatic random_buffer();
    int   kind;
    int   body;
    int   len;
    int   r;
    logic delta;
    kind  = $urandom_range(0, 99);
    delta = 1'($urandom_range(0, 1));
    if (kind < 45) begin
      repeat ($urandom_range(1, 4)) begin
        body = $urandom_range(0, 6);
        add_prefix(body + 1);
        frame = {frame, pick_header()};
        add_body(body);
      end
      if ($urandom_range(0, 19) == 0) begin
        add_prefix(0);
        add_body($urandom_range(1, 3));
      end
      if ($urandom_range(0, 9) == 0) begin
        frame[$urandom_range(0, frame.size() - 1)] = vknd_pkg::ByteW'($urandom);
      end
    end else if (kind < 80) begin
      add_body($urandom_range(0, 2));
      repeat ($urandom_range(1, 3)) begin
        frame = {frame, 8'h00, 8'h00};
        if ($urandom_range(0, 1) == 1) begin
          frame = {frame, 8'h00};
        end
        frame = {frame, 8'h01};
        frame = {frame, pick_header()};
        add_body($urandom_range(0, 6));
      end
    end else begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 2) == 0) begin
          frame = {frame, vknd_pkg::ByteW'($urandom)};
        end else begin
          frame = {frame, (($urandom_range(0, 2) == 0) ? 8'h01 : 8'h00)};
        end
      end
    end
    len = frame.size();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      len = $urandom_range(0, len);
    end else if (r < 12) begin
      len = len + $urandom_range(1, 4);
    end else if (r < 15) begin
      len = $urandom_range(MaxBytes, (1 << vknd_pkg::LenW) - 1);
    end else if (r < 18) begin
      len = $urandom_range(0, (1 << vknd_pkg::LenW) - 1);
    end
    send_frame(len, delta);
  endtask

  task automatic test_start_codes_h264();
    frame = '{8'h00, 8'h00, 8'h01, 8'h65, 8'h00};
    send_frame(5, 1'b1);
    // The header byte of a short start code is the final byte here, so it is not taken as a NAL header.
    frame = '{8'h00, 8'h00, 8'h01, 8'h65};
    send_frame(4, 1'b0);
    settle();
  endtask

  task automatic test_length_prefix_h265();
    write_codec(vknd_pkg::CODEC_H265);
    frame = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h26, 8'h01};
    send_frame(6, 1'b1);
    frame = '{8'h26};
    send_frame(0, 1'b0);
    settle();
  endtask

  task automatic test_length_limits();
    write_codec(vknd_pkg::CODEC_H264);
    frame = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h25};
    send_frame((1 << vknd_pkg::LenW) - 1, 1'b0);
    frame = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h25};
    send_frame(2, 1'b0);
    settle();
  endtask

  task automatic test_vp8();
    write_codec(vknd_pkg::CODEC_VP8);
    frame = '{8'hFE};
    send_frame(1, 1'b1);
    frame = '{8'h01, 8'h00};
    send_frame(0, 1'b0);
    settle();
  endtask

  task automatic test_other_and_audio();
    write_codec(vknd_pkg::CODEC_OTHER);
    frame = '{8'hAA};
    send_frame(1, 1'b0);
    frame = '{8'h55};
    send_frame(1, 1'b1);
    settle();
    // Codes above audio are treated as other video.
    write_codec(3'd7);
    frame = '{8'h00};
    send_frame(1, 1'b1);
    settle();
    write_codec(vknd_pkg::CODEC_AUDIO);
    frame = '{8'hFF};
    send_frame(1, 1'b1);
    settle();
  endtask

  task automatic test_random_streams();
    int first_byte;
    int first_buffer;
    int phase;
    int phase_start;
    logic [vknd_pkg::ModeW-1:0] mode;
    first_byte   = bytes_sent;
    first_buffer = buffers_sent;
    phase        = 0;
    while (bytes_sent - first_byte < 800 || buffers_sent - first_buffer < 60) begin
      if (phase < 8) begin
        mode = vknd_pkg::ModeW'(phase);
      end else if ($urandom_range(0, 3) == 0) begin
        mode = vknd_pkg::ModeW'($urandom_range(0, 7));
      end else begin
        mode = vknd_pkg::ModeW'($urandom_range(0, 1));
      end
      settle();
      write_codec(mode);
      rush = $urandom_range(0, 3) == 0;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 70) begin
        random_buffer();
      end
      phase++;
    end
    rush = 1'b0;
    settle();
  endtask

  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_data            = vknd_pkg::CODEC_H264;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.buffer_length = '0;
    in_ch.delta_flag    = 1'b0;
    in_ch.last_byte     = 1'b0;
    out_ch.ready        = 1'b0;
    rush                = 1'b0;
    stall_left          = 0;
    errors              = 0;
    bytes_sent          = 0;
    buffers_sent        = 0;
    verdicts_checked    = 0;
    codec_now           = vknd_pkg::CODEC_H264;
    clear_scan();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_start_codes_h264();
    test_length_prefix_h265();
    test_length_limits();
    test_vp8();
    test_other_and_audio();
    test_random_streams();

    repeat (8) @(posedge clk);
    $display("Sent %0d bytes in %0d buffers, checked %0d verdicts, %0d mismatches",
             bytes_sent, buffers_sent, verdicts_checked, errors);
    $display("Codec modes 0 to 7 ran with start-code, length-prefix and raw buffers");
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #15000000;
    $display("%0t: timeout with %0d verdicts outstanding", $time, expected_verdicts.size());
    $display("tb failed");
    $finish;
  end

endmodule
